>>> hdl/first_fit_page_extent_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page extent allocator checker
// Clocked implication helpers, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_PAGE_EXTENT_ALLOCATOR_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define FFPA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffpa assertion failed");

// ante implies cons in the next cycle
`define FFPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffpa assertion failed");

`endif

>>> hdl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants and types of the first-fit page extent allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

   localparam int MAX_EXTENTS = 64;
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int ADDR_W      = 52;
   localparam int PAGE_W      = 40;
   localparam int IDX_W       = $clog2(MAX_EXTENTS);
   localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_MEMORY  = 2'd1,
      STATUS_TABLE_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_FOUND,
      ST_CMP_RD,
      ST_CMP_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] count;
   } extent_type;

endpackage

>>> hdl/first_fit_page_extent_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_page_extent_allocator_core
// First-fit allocator over an ordered table of free physical page extents.
// ----------------------------------------------------------------------------
//  req_* channel (valid/ready): one beat per command. mode 0 appends a usable
//  memory-map region (base raised to one page, rounded up, length truncated
//  to pages), mode 1 allocates page_count pages from the top of the first
//  extent large enough, mode 2 appends a freed extent without merging.
//  rsp_* channel (valid/ready): one beat per request, the allocated byte
//  address (0 otherwise) and status ok / no_memory / table_full.
//  Add/free write the table in the append state; allocate reads and checks
//  the extents slot by slot until one fits (or all miss), and when the
//  chosen extent empties, the later extents close up one slot at a time,
//  each with a read and a write. The extent RAM has one read and one write port.
//  req_ready is high only while idle, so one request is in work at a time; the
//  next beat can be taken in the cycle in which rsp_valid rises.
//  A stalled rsp beat holds the rsp register; the next request is still
//  accepted and its result waits in the sequencer until rsp frees up.
//  Reset (synchronous) empties the table (fill count only) and drops any beat.
// ----------------------------------------------------------------------------
module first_fit_page_extent_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic                        req_region_usable,
   input  logic [ffpa_pkg::ADDR_W-1:0] req_byte_address,
   input  logic [ffpa_pkg::ADDR_W-1:0] req_region_length,
   input  logic [ffpa_pkg::PAGE_W-1:0] req_page_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ffpa_pkg::ADDR_W-1:0] rsp_result_address,
   output logic [1:0]                  rsp_status
);

   // extent table RAM: one write port, one registered read port
   ffpa_pkg::extent_type ext_mem [ffpa_pkg::MAX_EXTENTS];
   ffpa_pkg::extent_type rd_data_ff;
   ffpa_pkg::extent_type wr_data;
   logic [ffpa_pkg::IDX_W-1:0] rd_addr, wr_addr;
   logic rd_en, wr_en;

   // sequencer and captured request
   ffpa_pkg::state_type state_ff, state_in;
   logic [1:0]                  mode_ff, mode_in;
   logic                        usable_ff, usable_in;
   logic [ffpa_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [ffpa_pkg::ADDR_W-1:0] len_ff, len_in;
   logic [ffpa_pkg::PAGE_W-1:0] pages_ff, pages_in;

   // table bookkeeping
   logic [ffpa_pkg::CNT_W-1:0]  used_ff, used_in;
   logic [ffpa_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [ffpa_pkg::CNT_W-1:0]  idx_next;
   logic [ffpa_pkg::PAGE_W-1:0] left_ff, left_in;

   // result held until the response register is free
   logic [ffpa_pkg::ADDR_W-1:0] res_addr_ff, res_addr_in;
   ffpa_pkg::status_type        res_status_ff, res_status_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ffpa_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;

   // append path
   logic [ffpa_pkg::PAGE_W-1:0] app_base;
   logic [ffpa_pkg::PAGE_W-1:0] app_count;
   logic                        table_full;
   logic [ffpa_pkg::PAGE_W-1:0] end_page;

   assign req_ready          = (state_ff == ffpa_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

   assign idx_next   = idx_ff + ffpa_pkg::CNT_W'(1);
   assign table_full = (used_ff == ffpa_pkg::CNT_W'(ffpa_pkg::MAX_EXTENTS));
   assign end_page   = rd_data_ff.base + left_ff;

   // base page for an append: add regions are raised to page 1 and rounded
   // up; freed blocks just drop the in-page offset
   always_comb begin
      if (mode_ff == ffpa_pkg::MODE_ADD) begin
         if (addr_ff[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT] == '0) begin
            app_base = ffpa_pkg::PAGE_W'(1);
         end else begin
            app_base = addr_ff[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT]
                     + ffpa_pkg::PAGE_W'(|addr_ff[ffpa_pkg::PAGE_SHIFT-1:0]);
         end
         app_count = len_ff[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT];
      end else begin
         app_base  = addr_ff[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT];
         app_count = pages_ff;
      end
   end

   // next state, RAM control and register updates
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      usable_in     = usable_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      pages_in      = pages_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[ffpa_pkg::IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[ffpa_pkg::IDX_W-1:0];
      wr_data       = rd_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ffpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               usable_in     = req_region_usable;
               addr_in       = req_byte_address;
               len_in        = req_region_length;
               pages_in      = req_page_count;
               idx_in        = '0;
               res_addr_in   = '0;
               res_status_in = ffpa_pkg::STATUS_OK;
               case (req_mode)
                  ffpa_pkg::MODE_ADD:   state_in = ffpa_pkg::ST_APPEND;
                  ffpa_pkg::MODE_FREE:  state_in = ffpa_pkg::ST_APPEND;
                  ffpa_pkg::MODE_ALLOC: state_in = ffpa_pkg::ST_SRCH_RD;
                  default:              state_in = ffpa_pkg::ST_DONE;
               endcase
            end
         end
         ffpa_pkg::ST_APPEND: begin
            // unusable regions are ignored, even with a full table
            if (mode_ff != ffpa_pkg::MODE_ADD || usable_ff) begin
               if (table_full) begin
                  res_status_in = ffpa_pkg::STATUS_TABLE_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = used_ff[ffpa_pkg::IDX_W-1:0];
                  wr_data = '{base: app_base, count: app_count};
                  used_in = used_ff + ffpa_pkg::CNT_W'(1);
               end
            end
            state_in = ffpa_pkg::ST_DONE;
         end
         ffpa_pkg::ST_SRCH_RD: begin
            if (idx_ff >= used_ff) begin
               res_status_in = ffpa_pkg::STATUS_NO_MEMORY;
               state_in      = ffpa_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ffpa_pkg::ST_SRCH_CHK;
            end
         end
         ffpa_pkg::ST_SRCH_CHK: begin
            if (rd_data_ff.count >= pages_ff) begin
               left_in  = rd_data_ff.count - pages_ff;
               state_in = ffpa_pkg::ST_FOUND;
            end else begin
               idx_in   = idx_next;
               state_in = ffpa_pkg::ST_SRCH_RD;
            end
         end
         ffpa_pkg::ST_FOUND: begin
            // carve from the top end of the chosen extent
            res_addr_in = {end_page, {ffpa_pkg::PAGE_SHIFT{1'b0}}};
            if (left_ff == '0) begin
               state_in = ffpa_pkg::ST_CMP_RD;
            end else begin
               wr_en    = 1'b1;
               wr_data  = '{base: rd_data_ff.base, count: left_ff};
               state_in = ffpa_pkg::ST_DONE;
            end
         end
         ffpa_pkg::ST_CMP_RD: begin
            // close the gap: slot idx takes slot idx+1
            if (idx_next >= used_ff) begin
               used_in  = used_ff - ffpa_pkg::CNT_W'(1);
               state_in = ffpa_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_next[ffpa_pkg::IDX_W-1:0];
               state_in = ffpa_pkg::ST_CMP_WR;
            end
         end
         ffpa_pkg::ST_CMP_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_next;
            state_in = ffpa_pkg::ST_CMP_RD;
         end
         ffpa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ffpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffpa_pkg::ST_IDLE;
         end
      endcase
   end

   // extent RAM
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ext_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ext_mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffpa_pkg::ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      usable_ff     <= usable_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      pages_ff      <= pages_in;
      idx_ff        <= idx_in;
      left_ff       <= left_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

>>> hdl/ffpa_checker.sv
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the page extent allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_page_extent_allocator_core_assert.svh"

module ffpa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ffpa_pkg::ADDR_W-1:0] rsp_result_address,
   input logic [1:0]                  rsp_status
);

   // a stalled response beat holds its payload
   `FFPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_address) && $stable(rsp_status))

   // only successful allocations carry an address
   `FFPA_ASSERT_IMPL(a_fail_no_addr, clock, reset, rsp_valid && rsp_status != ffpa_pkg::STATUS_OK, rsp_result_address == '0)

   // one request in work at a time
   `FFPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // reset drops any pending response
   `FFPA_ASSERT_IMPL(a_reset_clears, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind first_fit_page_extent_allocator_core ffpa_checker u_ffpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_address (rsp_result_address),
   .rsp_status         (rsp_status)
);

>>> tb/sv/tb_first_fit_page_extent_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_extent_allocator_core
// Self-checking bench for the first-fit page extent allocator. A scoreboard
// model of the extent table predicts every response beat. The stimulus runs
// directed corners, a full-table pass, output back-pressure and a long
// random mix, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_first_fit_page_extent_allocator_core;

   localparam int RANDOM_ITEMS  = 1300;
   localparam int DRAIN_LIMIT   = 200000;
   // worst allocate: full scan plus full close-up
   localparam int SETTLE_CYCLES = 300;
   localparam int PRESSURE_HOLD = 200;

   typedef struct packed {
      logic [ffpa_pkg::ADDR_W-1:0] address;
      ffpa_pkg::status_type        status;
   } alloc_rsp_type;

   typedef struct packed {
      logic [ffpa_pkg::ADDR_W-1:0] address;
      logic [ffpa_pkg::PAGE_W-1:0] pages;
   } held_block_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_mode;
   logic                        req_region_usable;
   logic [ffpa_pkg::ADDR_W-1:0] req_byte_address;
   logic [ffpa_pkg::ADDR_W-1:0] req_region_length;
   logic [ffpa_pkg::PAGE_W-1:0] req_page_count;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [ffpa_pkg::ADDR_W-1:0] rsp_result_address;
   logic [1:0]                  rsp_status;

   // scoreboard copy of the free-extent table
   logic [ffpa_pkg::PAGE_W-1:0] ext_base_page [ffpa_pkg::MAX_EXTENTS];
   logic [ffpa_pkg::PAGE_W-1:0] ext_page_cnt  [ffpa_pkg::MAX_EXTENTS];
   int                          ext_used = 0;

   alloc_rsp_type  expected_rsp_q[$];
   held_block_type held_blocks[$];

   int errors          = 0;
   int beats_checked   = 0;
   int rsp_hold_cycles = 0;
   bit idle_on         = 1'b1;
   int mode_seen[3]    = '{0, 0, 0};
   int status_seen[3]  = '{0, 0, 0};

   first_fit_page_extent_allocator_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_region_usable  (req_region_usable),
      .req_byte_address   (req_byte_address),
      .req_region_length  (req_region_length),
      .req_page_count     (req_page_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #20_000_000;
      $display("%0t: timeout, %0d beats still outstanding", $time, expected_rsp_q.size());
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------
   function automatic logic [63:0] rand_word64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ffpa_pkg::ADDR_W-1:0] rand_addr();
      return ffpa_pkg::ADDR_W'(rand_word64());
   endfunction

   function automatic logic [ffpa_pkg::PAGE_W-1:0] rand_pages();
      return ffpa_pkg::PAGE_W'(rand_word64());
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ---------------------------------------------------------------------
   // Table model
   // ---------------------------------------------------------------------
   function automatic ffpa_pkg::status_type append_extent(
         input logic [ffpa_pkg::PAGE_W-1:0] base,
         input logic [ffpa_pkg::PAGE_W-1:0] pages);
      if (ext_used >= ffpa_pkg::MAX_EXTENTS)
         return ffpa_pkg::STATUS_TABLE_FULL;
      ext_base_page[ext_used] = base;
      ext_page_cnt[ext_used]  = pages;
      ext_used++;
      return ffpa_pkg::STATUS_OK;
   endfunction

   // Applies one request to the model table and returns the response beat.
   function automatic alloc_rsp_type step_extent_table(
         input ffpa_pkg::mode_type          mode,
         input logic                        usable,
         input logic [ffpa_pkg::ADDR_W-1:0] addr,
         input logic [ffpa_pkg::ADDR_W-1:0] len,
         input logic [ffpa_pkg::PAGE_W-1:0] pages);
      alloc_rsp_type               rsp;
      logic [ffpa_pkg::ADDR_W:0]   rounded;
      logic [ffpa_pkg::PAGE_W-1:0] left;
      logic [ffpa_pkg::PAGE_W-1:0] top_page;
      int                          hit;
      rsp.address = '0;
      rsp.status  = ffpa_pkg::STATUS_OK;
      hit         = -1;
      case (mode)
         ffpa_pkg::MODE_ADD: begin
            if (usable) begin
               // low memory is never handed out; round base up to a page
               rounded = {1'b0, addr};
               if (addr < ffpa_pkg::PAGE_BYTES)
                  rounded = (ffpa_pkg::ADDR_W + 1)'(ffpa_pkg::PAGE_BYTES);
               rounded = rounded + (ffpa_pkg::ADDR_W + 1)'(ffpa_pkg::PAGE_BYTES - 1);
               rsp.status = append_extent(rounded[ffpa_pkg::PAGE_SHIFT +: ffpa_pkg::PAGE_W],
                                          len[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT]);
            end
         end
         ffpa_pkg::MODE_ALLOC: begin
            for (int i = 0; i < ext_used; i++) begin
               if (ext_page_cnt[i] >= pages) begin
                  hit = i;
                  break;
               end
            end
            if (hit < 0) begin
               rsp.status = ffpa_pkg::STATUS_NO_MEMORY;
            end else begin
               // carve from the top end of the chosen extent
               left        = ext_page_cnt[hit] - pages;
               top_page    = ext_base_page[hit] + left;
               rsp.address = {top_page, {ffpa_pkg::PAGE_SHIFT{1'b0}}};
               if (left == '0) begin
                  for (int i = hit; i + 1 < ext_used; i++) begin
                     ext_base_page[i] = ext_base_page[i + 1];
                     ext_page_cnt[i]  = ext_page_cnt[i + 1];
                  end
                  ext_used--;
               end else begin
                  ext_page_cnt[hit] = left;
               end
            end
         end
         ffpa_pkg::MODE_FREE: begin
            rsp.status = append_extent(addr[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT], pages);
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: one beat, payload set at the falling edge, held until
   // accepted. Valid stays high into the next call if that has no gap.
   // ---------------------------------------------------------------------
   task automatic send_request(input  ffpa_pkg::mode_type          mode,
                               input  logic                        usable,
                               input  logic [ffpa_pkg::ADDR_W-1:0] addr,
                               input  logic [ffpa_pkg::ADDR_W-1:0] len,
                               input  logic [ffpa_pkg::PAGE_W-1:0] pages,
                               output alloc_rsp_type               predicted);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode          = mode;
      req_region_usable = usable;
      req_byte_address  = addr;
      req_region_length = len;
      req_page_count    = pages;
      req_valid         = 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = step_extent_table(mode, usable, addr, len, pages);
      expected_rsp_q.push_back(predicted);
      mode_seen[int'(mode)]++;
      status_seen[int'(predicted.status)]++;
   endtask

   // ---------------------------------------------------------------------
   // Response sink: random stalls, plus a long hold when a test asks.
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left      = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready  = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response checker: each beat against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      alloc_rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected beat, address %h status %0d",
                     $time, rsp_result_address, rsp_status);
            errors++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_result_address !== exp_rsp.address) begin
               $display("%0t: result_address mismatch, expected %h actual %h",
                        $time, exp_rsp.address, rsp_result_address);
               errors++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, exp_rsp.status, rsp_status);
               errors++;
            end
            beats_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_corners();
      alloc_rsp_type rsp;
      // empty table misses, zero pages too
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, 40'd1, rsp);
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, '0, rsp);
      // unusable region is ignored
      send_request(ffpa_pkg::MODE_ADD, 1'b0, 52'h5000, 52'h10000, '0, rsp);
      // base 0 raised to one page, partial page of length dropped
      send_request(ffpa_pkg::MODE_ADD, 1'b1, '0, 52'h3FFF, '0, rsp);
      // sub-page length still appends a zero-page extent
      send_request(ffpa_pkg::MODE_ADD, 1'b1, 52'h1, 52'hFFF, '0, rsp);
      // unaligned base rounds up
      send_request(ffpa_pkg::MODE_ADD, 1'b1, 52'h1001, 52'h8000, '0, rsp);
      // top of address space: base page wraps, longest length
      send_request(ffpa_pkg::MODE_ADD, 1'b1, '1, '1, '1, rsp);
      send_request(ffpa_pkg::MODE_ADD, 1'b1, 52'h1000, 52'h2000, '0, rsp);
      // zero pages on a non-empty head returns its end address
      send_request(ffpa_pkg::MODE_ALLOC, 1'b1, '1, '1, '0, rsp);
      // exact fit empties the head, the rest close up
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, 40'd3, rsp);
      // zero pages on the zero-page head removes it
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, '0, rsp);
      // head large enough, its top carved
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, 40'd5, rsp);
      // largest request: exact fit on the wrapped region, then a miss
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, '1, rsp);
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, '1, rsp);
      // free drops the low address bits; zero and full page counts
      send_request(ffpa_pkg::MODE_FREE, 1'b1, 52'h0000_ABCD_EFFF, '1, '0, rsp);
      send_request(ffpa_pkg::MODE_FREE, 1'b0, '1, '0, '1, rsp);
      // carve from the very top of the address space
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, '1, rsp);
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, 40'd2, rsp);
      // base just under one page
      send_request(ffpa_pkg::MODE_ADD, 1'b1, 52'hFFF, 52'h1000, '0, rsp);
   endtask

   task automatic test_table_full();
      alloc_rsp_type rsp;
      while (ext_used < ffpa_pkg::MAX_EXTENTS)
         send_request(ffpa_pkg::MODE_FREE, 1'b0, rand_addr(), rand_addr(),
                      ffpa_pkg::PAGE_W'($urandom_range(1, 32)), rsp);
      send_request(ffpa_pkg::MODE_ADD, 1'b1, 52'h10_0000, 52'h4000, '0, rsp);
      send_request(ffpa_pkg::MODE_FREE, 1'b0, 52'h20_0000, '0, 40'd4, rsp);
      // unusable add is ignored, not flagged, even when full
      send_request(ffpa_pkg::MODE_ADD, 1'b0, 52'h30_0000, 52'h4000, '0, rsp);
      // head removal closes up the whole table; one slot opens, then full again
      send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, ext_page_cnt[0], rsp);
      send_request(ffpa_pkg::MODE_FREE, 1'b0, 52'h40_0000, '0, 40'd7, rsp);
      send_request(ffpa_pkg::MODE_FREE, 1'b0, 52'h50_0000, '0, 40'd7, rsp);
      // empty the table through repeated head removal
      while (ext_used > 0)
         send_request(ffpa_pkg::MODE_ALLOC, 1'b0, rand_addr(), rand_addr(),
                      ext_page_cnt[0], rsp);
   endtask

   // Sink holds off while the driver keeps offering; the block stalls req.
   task automatic test_backpressure();
      alloc_rsp_type rsp;
      idle_on         = 1'b0;
      rsp_hold_cycles = PRESSURE_HOLD;
      for (int n = 0; n < 16; n++) begin
         if (n % 2 == 0)
            send_request(ffpa_pkg::MODE_ADD, 1'b1,
                         ffpa_pkg::ADDR_W'((n + 1) * 32'h10_0000), 52'h8000, '0, rsp);
         else
            send_request(ffpa_pkg::MODE_ALLOC, 1'b0, '0, '0, 40'd1, rsp);
      end
      idle_on = 1'b1;
   endtask

   task automatic send_random_item(input int fill_limit);
      alloc_rsp_type               rsp;
      held_block_type              blk;
      logic [ffpa_pkg::PAGE_W-1:0] pages;
      logic [ffpa_pkg::ADDR_W-1:0] addr;
      logic [ffpa_pkg::ADDR_W-1:0] len;
      logic [63:0]                 span;
      int                          pick;
      int                          slot;
      pick = $urandom_range(0, 99);
      // above the fill limit, mostly exact-fit allocations to trim the table
      if (ext_used > fill_limit && $urandom_range(0, 9) < 7)
         pick = 100;
      if (pick == 100 || pick < 30) begin
         if (ext_used == 0) begin
            pages = ffpa_pkg::PAGE_W'($urandom_range(0, 4));
         end else begin
            slot = $urandom_range(0, ext_used - 1);
            span = 64'(ext_page_cnt[slot]) + 64'd1;
            if (pick == 100 || $urandom_range(0, 3) == 0)
               pages = ext_page_cnt[slot];
            else
               pages = ffpa_pkg::PAGE_W'(rand_word64() % span);
         end
         send_request(ffpa_pkg::MODE_ALLOC, 1'($urandom_range(0, 1)), rand_addr(),
                      rand_addr(), pages, rsp);
         if (rsp.status == ffpa_pkg::STATUS_OK) begin
            blk.address = rsp.address;
            blk.pages   = pages;
            held_blocks.push_back(blk);
            if (held_blocks.size() > 128)
               void'(held_blocks.pop_front());
         end
      end else if (pick < 50) begin
         addr = ($urandom_range(0, 3) == 0) ? ffpa_pkg::ADDR_W'($urandom_range(0, 8191))
                                            : rand_addr();
         if ($urandom_range(0, 7) == 0)
            len = rand_addr();
         else
            len = ffpa_pkg::ADDR_W'($urandom_range(0, 64) * ffpa_pkg::PAGE_BYTES
                                    + $urandom_range(0, ffpa_pkg::PAGE_BYTES - 1));
         send_request(ffpa_pkg::MODE_ADD, 1'b1, addr, len, rand_pages(), rsp);
      end else if (pick < 70) begin
         if (held_blocks.size() > 0) begin
            slot = $urandom_range(0, held_blocks.size() - 1);
            blk  = held_blocks[slot];
            held_blocks.delete(slot);
            addr = blk.address;
            if ($urandom_range(0, 3) == 0)
               addr = addr | ffpa_pkg::ADDR_W'($urandom_range(0, ffpa_pkg::PAGE_BYTES - 1));
            send_request(ffpa_pkg::MODE_FREE, 1'($urandom_range(0, 1)), addr, rand_addr(),
                         blk.pages, rsp);
         end else begin
            send_request(ffpa_pkg::MODE_FREE, 1'($urandom_range(0, 1)), rand_addr(),
                         rand_addr(), ffpa_pkg::PAGE_W'($urandom_range(0, 64)), rsp);
         end
      end else if (pick < 80) begin
         send_request(ffpa_pkg::MODE_ADD, 1'b0, rand_addr(), rand_addr(), rand_pages(), rsp);
      end else if (pick < 90) begin
         send_request(ffpa_pkg::mode_type'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                      rand_addr(), rand_addr(), rand_pages(), rsp);
      end else begin
         // oversize request, nearly always a miss
         send_request(ffpa_pkg::MODE_ALLOC, 1'b0, rand_addr(), rand_addr(),
                      rand_pages() | {1'b1, {(ffpa_pkg::PAGE_W - 1){1'b0}}}, rsp);
      end
   endtask

   task automatic test_random_traffic();
      int fill_limit;
      fill_limit = ffpa_pkg::MAX_EXTENTS / 2;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // new stretch: idle on or off, and a new target table depth
         if (n % 100 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
               0: fill_limit = 16;
               1: fill_limit = 40;
               default: fill_limit = ffpa_pkg::MAX_EXTENTS - 2;
            endcase
         end
         send_random_item(fill_limit);
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int waited;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = ffpa_pkg::MODE_ADD;
      req_region_usable = 1'b0;
      req_byte_address  = '0;
      req_region_length = '0;
      req_page_count    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_table_full();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid = 1'b0;
      waited    = 0;
      while (expected_rsp_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, expected_rsp_q.size());
         errors++;
      end

      $display("Checked %0d beats: %0d add, %0d allocate, %0d free requests",
               beats_checked, mode_seen[0], mode_seen[1], mode_seen[2]);
      $display("Status mix: %0d ok, %0d no_memory, %0d table_full, %0d errors",
               status_seen[0], status_seen[1], status_seen[2], errors);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
